// ===== hw/rtl/mtefd_pkg.sv =====
// Shared types and constants of the multi-turn encoder feedback decoder.
// No dependencies; used by mtefd_state_mem and the top level.
`timescale 1ns / 1ps

package mtefd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE_ID = 3'd0;
  localparam logic [2:0] REG_GEAR_0  = 3'd1;
  localparam logic [2:0] REG_GEAR_1  = 3'd2;
  localparam logic [2:0] REG_GEAR_2  = 3'd3;
  localparam logic [2:0] REG_GEAR_3  = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ID_W       = 11;
  localparam int MOTOR_SLOTS = 4;

  localparam logic [10:0] BASE_ID_RST = 11'd513;
  localparam logic [15:0] GEAR_RST    = 16'd9216;

  // round(2*pi * 2^29)
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // Divider operand widths: angle numerator, gear*counts*32, speed numerator, gear.
  localparam int NUM_A_W = 64;
  localparam int DEN_A_W = 37;
  localparam int NUM_S_W = 40;
  localparam int DEN_S_W = 16;

  localparam logic [31:0] INT32_MIN_BITS = 32'h8000_0000;
  localparam logic [31:0] INT32_MAX_BITS = 32'h7FFF_FFFF;

  // One tracking entry per motor.
  typedef struct packed {
    logic signed [15:0] last_angle;
    logic signed [15:0] turn_count;
    logic signed [15:0] zero_offset;
  } entry_t;

  // Read and write command to the state memory.
  typedef struct packed {
    logic   rd;
    logic   wr;
    entry_t wr_data;
  } mem_cmd_t;

endpackage

// ===== hw/rtl/mtefd_state_mem.sv =====
// Per-motor tracking memory with one synchronous port and a seen bit per entry.
// Depends on mtefd_pkg for the entry and command types.
`timescale 1ns / 1ps

module mtefd_state_mem #(
  parameter int DEPTH  = 4,
  parameter int ADDR_W = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mtefd_pkg::mem_cmd_t cmd,
  input  logic [ADDR_W-1:0]   addr,
  output mtefd_pkg::entry_t   rd_entry,
  output logic                rd_seen
);

  mtefd_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0]  seen_r;
  logic [DEPTH-1:0]  seen_nxt;
  mtefd_pkg::entry_t rd_entry_r;
  logic              rd_seen_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= cmd.wr_data;
    end
    if (cmd.rd) begin
      rd_entry_r <= mem[addr];
      rd_seen_r  <= seen_r[addr];
    end
  end

  // The seen bits stand in for the cleared reset state of the whole memory.
  always_comb begin
    seen_nxt = seen_r;
    if (cmd.wr) begin
      seen_nxt[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_seen  = rd_seen_r;

endmodule

// ===== hw/rtl/mtefd_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module mtefd_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 37
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[NUM_W-1]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The numerator shifts out at the top while quotient bits enter below.
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = DEN_W'(trial);
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ===== hw/rtl/multiturn_encoder_feedback_decoder.sv =====
// Top level: frame filter, turn tracking, fixed-point scaling and result register.
// Depends on mtefd_pkg, mtefd_state_mem and mtefd_divider.
`timescale 1ns / 1ps

// Decodes motor-controller feedback frames into a multi-turn output axis angle
// (signed Q16.16 radians) and axis speed (Q16.16), both divided by the motor's
// Q8.8 gear ratio, rounded to nearest and saturated; the current word is passed
// through. Extended frames and identifiers outside base_id..base_id+3 (or beyond
// NUM_MOTORS) are taken and dropped. The first frame of a motor records its
// zero offset and gives no result. Every later frame runs through the states
// READ, PROD, POS, MUL, RND, START, WAIT and OUT to a result in the output
// register, the 64-step angle divider taking longest; one frame is in work at
// a time. The output register lets a new frame be taken while a result waits.
module multiturn_encoder_feedback_decoder #(
  parameter int NUM_MOTORS      = 4,
  parameter int COUNTS_PER_TURN = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: frame_id[10:0], angle_raw[26:11], speed_raw[42:27],
  //           current_raw[58:43], zero fill[63:59]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // in_tuser: is_standard[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: axis_angle[31:0], axis_speed[63:32], torque_current[79:64]
  output logic [79:0] out_tdata,
  // out_tuser: motor_index[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [mtefd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtefd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_SLOTS = (NUM_MOTORS < mtefd_pkg::MOTOR_SLOTS) ?
                             NUM_MOTORS : mtefd_pkg::MOTOR_SLOTS;
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [15:0]        CPT_U    = 16'(COUNTS_PER_TURN);
  localparam logic signed [32:0] CPT_S    = 33'(COUNTS_PER_TURN);
  localparam logic signed [16:0] HALF     = 17'(COUNTS_PER_TURN / 2);
  localparam logic signed [16:0] NEG_HALF = -17'(COUNTS_PER_TURN / 2);
  localparam logic signed [15:0] TURN_MIN = 16'sh8000;
  localparam logic signed [15:0] TURN_MAX = 16'sh7FFF;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_PROD  = 4'd2;
  localparam logic [3:0] S_POS   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_RND   = 4'd5;
  localparam logic [3:0] S_START = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  function automatic logic [31:0] sat_q(input logic [63:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (q > 64'h8000_0000) r = mtefd_pkg::INT32_MIN_BITS;
      else                   r = 32'(64'd0 - q);
    end else begin
      if (q > 64'h7FFF_FFFF) r = mtefd_pkg::INT32_MAX_BITS;
      else                   r = q[31:0];
    end
    return r;
  endfunction

  // Input fields.
  logic [10:0]        in_frame_id;
  logic signed [15:0] in_angle, in_speed, in_current;
  assign in_frame_id = in_tdata[10:0];
  assign in_angle    = in_tdata[26:11];
  assign in_speed    = in_tdata[42:27];
  assign in_current  = in_tdata[58:43];

  // Configuration registers.
  logic [10:0] base_id_r, base_id_nxt;
  logic [15:0] gear_r [mtefd_pkg::MOTOR_SLOTS];
  logic [15:0] gear_nxt [mtefd_pkg::MOTOR_SLOTS];

  always_comb begin
    base_id_nxt = base_id_r;
    gear_nxt    = gear_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mtefd_pkg::REG_BASE_ID: base_id_nxt = cfg_data[10:0];
        mtefd_pkg::REG_GEAR_0:  gear_nxt[0] = cfg_data;
        mtefd_pkg::REG_GEAR_1:  gear_nxt[1] = cfg_data;
        mtefd_pkg::REG_GEAR_2:  gear_nxt[2] = cfg_data;
        mtefd_pkg::REG_GEAR_3:  gear_nxt[3] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r <= mtefd_pkg::BASE_ID_RST;
      for (int i = 0; i < mtefd_pkg::MOTOR_SLOTS; i++) gear_r[i] <= mtefd_pkg::GEAR_RST;
    end else begin
      base_id_r <= base_id_nxt;
      gear_r    <= gear_nxt;
    end
  end

  // Control state.
  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Work registers of the frame in progress.
  logic [1:0]         idx_r;
  logic signed [15:0] angle_r, speed_r, cur_r;
  logic signed [15:0] turn_r, zero_r;
  logic [15:0]        g_r;
  logic signed [32:0] prod_r;
  logic [mtefd_pkg::DEN_A_W-1:0] den_a_r;
  logic [mtefd_pkg::NUM_S_W-1:0] num_s_r;
  logic               neg_s_r;
  logic [31:0]        mag_r;
  logic               neg_a_r;
  logic [63:0]        mul_r;
  logic [mtefd_pkg::NUM_A_W-1:0] num_a_r;
  logic [1:0]         out_idx_r;
  logic [31:0]        out_angle_r, out_speed_r;
  logic [15:0]        out_cur_r;

  // Frame filter.
  logic [10:0] id_off;
  logic        frame_hit;
  logic        in_fire;
  assign id_off    = in_frame_id - base_id_r;
  assign frame_hit = in_tuser && (in_frame_id >= base_id_r) &&
                     (id_off < 11'(NUM_SLOTS));
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // State memory.
  mtefd_pkg::mem_cmd_t mem_cmd;
  mtefd_pkg::entry_t   rd_entry;
  logic                rd_seen;
  logic [IDX_W-1:0]    mem_addr;

  // Turn tracking against the stored entry.
  logic signed [16:0] diff;
  logic signed [15:0] turn_new;
  always_comb begin
    diff     = 17'(angle_r) - 17'(rd_entry.last_angle);
    turn_new = rd_entry.turn_count;
    if (diff > HALF && rd_entry.turn_count != TURN_MIN) begin
      turn_new = rd_entry.turn_count - 16'sd1;
    end else if (diff < NEG_HALF && rd_entry.turn_count != TURN_MAX) begin
      turn_new = rd_entry.turn_count + 16'sd1;
    end
  end

  always_comb begin
    mem_cmd.rd      = (state_r == S_IDLE) && in_fire && frame_hit;
    mem_cmd.wr      = (state_r == S_READ);
    mem_addr        = (state_r == S_IDLE) ? id_off[IDX_W-1:0] : idx_r[IDX_W-1:0];
    mem_cmd.wr_data.last_angle = angle_r;
    if (rd_seen) begin
      mem_cmd.wr_data.turn_count  = turn_new;
      mem_cmd.wr_data.zero_offset = rd_entry.zero_offset;
    end else begin
      // First frame of this motor: its angle becomes the zero point.
      mem_cmd.wr_data.turn_count  = 16'sd0;
      mem_cmd.wr_data.zero_offset = angle_r;
    end
  end

  mtefd_state_mem #(
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mem_cmd),
    .addr     (mem_addr),
    .rd_entry (rd_entry),
    .rd_seen  (rd_seen)
  );

  // Dividers for angle and speed, run side by side.
  logic        div_start;
  logic        busy_a, busy_s;
  logic [mtefd_pkg::NUM_A_W-1:0] quo_a;
  logic [mtefd_pkg::NUM_S_W-1:0] quo_s;
  assign div_start = (state_r == S_START);

  mtefd_divider #(
    .NUM_W (mtefd_pkg::NUM_A_W),
    .DEN_W (mtefd_pkg::DEN_A_W)
  ) u_div_angle (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_a_r),
    .den   (den_a_r),
    .busy  (busy_a),
    .quo   (quo_a)
  );

  mtefd_divider #(
    .NUM_W (mtefd_pkg::NUM_S_W),
    .DEN_W (mtefd_pkg::DEN_S_W)
  ) u_div_speed (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_s_r),
    .den   (g_r),
    .busy  (busy_s),
    .quo   (quo_s)
  );

  // Arithmetic between stages.
  logic signed [33:0] pos;
  logic signed [33:0] pos_abs;
  logic [31:0]        gc;
  logic [15:0]        speed_mag;
  always_comb begin
    pos       = 34'(angle_r) + 34'(prod_r) - 34'(zero_r);
    pos_abs   = pos[33] ? -pos : pos;
    gc        = 32'(g_r) * 32'(CPT_U);
    speed_mag = speed_r[15] ? 16'(-17'(speed_r)) : speed_r;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r   <= id_off[1:0];
      angle_r <= in_angle;
      speed_r <= in_speed;
      cur_r   <= in_current;
    end
    if (state_r == S_READ) begin
      turn_r <= turn_new;
      zero_r <= rd_entry.zero_offset;
      g_r    <= (gear_r[idx_r] == 16'd0) ? 16'd1 : gear_r[idx_r];
    end
    if (state_r == S_PROD) begin
      prod_r  <= 33'(turn_r) * CPT_S;
      den_a_r <= {gc, 5'b0};
      num_s_r <= {speed_mag, 24'b0} + mtefd_pkg::NUM_S_W'(g_r >> 1);
      neg_s_r <= speed_r[15];
    end
    if (state_r == S_POS) begin
      mag_r   <= pos_abs[31:0];
      neg_a_r <= pos[33];
    end
    if (state_r == S_MUL) begin
      mul_r <= 64'(mag_r) * 64'(mtefd_pkg::TWO_PI_Q29);
    end
    if (state_r == S_RND) begin
      num_a_r <= mul_r + 64'(den_a_r >> 1);
    end
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_idx_r   <= idx_r;
      out_angle_r <= sat_q(quo_a, neg_a_r);
      out_speed_r <= sat_q(64'(quo_s), neg_s_r);
      out_cur_r   <= cur_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE:  if (in_fire && frame_hit) state_nxt = S_READ;
      S_READ:  state_nxt = rd_seen ? S_PROD : S_IDLE;
      S_PROD:  state_nxt = S_POS;
      S_POS:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_RND;
      S_RND:   state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT:  if (!busy_a && !busy_s) state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_idx_r;
  assign out_tdata  = {out_cur_r, out_speed_r, out_angle_r};

endmodule

// ===== hw/rtl/mtefd_checker.sv =====
// Port-level checks of the multi-turn encoder feedback decoder, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module mtefd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An extended frame is dropped at once, so the input stays open for the next beat.
  a_drop_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("input closed after an extended frame");

  // No result can appear in the cycle after a frame is taken into an empty output.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared one cycle after a frame was accepted");

endmodule

bind multiturn_encoder_feedback_decoder mtefd_checker u_mtefd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
